@@ src/assert_macros.svh @@
// Assertion macros shared by the decoder modules.
// No dependencies; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

@@ src/opd_pkg.sv @@
// Package for the oversampled pad report decoder: sizes, register indexes,
// shared structs and the cell vote function. No dependencies.
package opd_pkg;

    localparam int REPORT_BYTES = 8;
    localparam int IDX_W = (REPORT_BYTES > 1) ? $clog2(REPORT_BYTES) : 1;
    localparam int POS_W = IDX_W + 2;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(4 * REPORT_BYTES - 1);

    typedef enum logic [1:0] {
        REG_VOTE_THRESHOLD = 2'd0,
        REG_HEADER_PATTERN = 2'd1,
        REG_CENTRE_OFFSET  = 2'd2
    } reg_index_t;

    localparam logic [1:0] VOTE_THRESHOLD_RESET = 2'd2;
    localparam logic [7:0] HEADER_PATTERN_RESET = 8'h11;
    localparam logic [7:0] CENTRE_OFFSET_RESET  = 8'd127;

    typedef struct packed {
        logic [1:0] vote_threshold;
        logic [7:0] header_pattern;
        logic [7:0] centre_offset;
    } cfg_t;

    typedef struct packed {
        logic [7:0] value;
        logic [2:0] position;
        logic       last;
    } result_t;

    function automatic logic cell_vote(input logic [3:0] samples, input logic [1:0] thr);
        logic [2:0] cnt;
        cnt = 3'(samples[0]) + 3'(samples[1]) + 3'(samples[2]) + 3'(samples[3]);
        return cnt > {1'b0, thr};
    endfunction

endpackage

@@ src/opd_cfg_regs.sv @@
// Configuration register file of the pad report decoder.
// Depends on opd_pkg for register indexes, reset values and cfg_t.
module opd_cfg_regs
    import opd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_VOTE_THRESHOLD: cfg_next.vote_threshold = cfg_data[1:0];
                REG_HEADER_PATTERN: cfg_next.header_pattern = cfg_data;
                REG_CENTRE_OFFSET:  cfg_next.centre_offset  = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vote_threshold <= VOTE_THRESHOLD_RESET;
            cfg_reg.header_pattern <= HEADER_PATTERN_RESET;
            cfg_reg.centre_offset  <= CENTRE_OFFSET_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/opd_frame_tracker.sv @@
// Frame position, header check, cell voting and report byte transform.
// Depends on opd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module opd_frame_tracker
    import opd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_fire,
    input  logic [7:0] sample_byte,
    input  logic       frame_start,
    output logic       res_valid,
    output result_t    res
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [5:0]       partial_reg;
    logic [5:0]       partial_next;
    logic             rejected_reg;
    logic             rejected_next;

    logic [POS_W-1:0] pos_eff;
    logic [5:0]       part;
    logic [1:0]       cells;
    logic [7:0]       raw_val;
    logic [IDX_W-1:0] idx;

    always_comb
    begin
        pos_eff = frame_start ? '0 : pos_reg;
        rejected_next = (pos_eff == '0) ? (sample_byte != cfg.header_pattern) : rejected_reg;
        part = (pos_eff[1:0] == 2'd0) ? 6'd0 : partial_reg;
        cells = {cell_vote(sample_byte[7:4], cfg.vote_threshold),
                 cell_vote(sample_byte[3:0], cfg.vote_threshold)};
        raw_val = {part, cells};
        idx = pos_eff[POS_W-1:2];

        if (32'(idx) == 2 || 32'(idx) == 4)
            res.value = raw_val + cfg.centre_offset;
        else if (32'(idx) == 3 || 32'(idx) == 5)
            res.value = cfg.centre_offset - raw_val;
        else
            res.value = raw_val;
        res.position = 3'(idx);
        res.last = (32'(idx) == REPORT_BYTES - 1);

        res_valid = in_fire && (pos_eff[1:0] == 2'd3) && !rejected_next;
        partial_next = (pos_eff[1:0] == 2'd3) ? 6'd0 : {part[3:0], cells};
        pos_next = (pos_eff == LAST_POS) ? '0 : pos_eff + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            partial_reg  <= '0;
            rejected_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            pos_reg      <= pos_next;
            partial_reg  <= partial_next;
            rejected_reg <= rejected_next;
        end
    end

    `ASSERT_PROP(a_partial_clear_on_byte, clk, rst_n, (pos_reg[1:0] == 2'd0) |-> (partial_reg == 6'd0), "partial bits left at byte boundary")
    `ASSERT_NEVER(a_pos_range, clk, rst_n, pos_reg > LAST_POS, "sample position beyond frame")
    `ASSERT_PROP(a_result_on_fourth, clk, rst_n, res_valid |-> (pos_eff[1:0] == 2'd3), "result off a fourth sample")

endmodule

@@ src/opd_out_buffer.sv @@
// Two-entry output buffer: main register plus skid register toward the sink.
// Depends on opd_pkg for result_t and on assert_macros.svh.
`include "assert_macros.svh"
module opd_out_buffer
    import opd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    input  result_t res,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    main_valid_reg;
    logic    main_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t main_reg;
    result_t main_next;
    result_t skid_reg;
    result_t skid_next;
    logic    drain;

    always_comb
    begin
        drain = main_valid_reg && out_ready;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next = main_reg;
        skid_next = skid_reg;
        if (drain)
        begin
            main_valid_next = skid_valid_reg;
            main_next = skid_reg;
            skid_valid_next = 1'b0;
        end
        if (res_valid)
        begin
            if (main_valid_next)
            begin
                skid_valid_next = 1'b1;
                skid_next = res;
            end
            else
            begin
                main_valid_next = 1'b1;
                main_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    `ASSERT_PROP(a_skid_needs_main, clk, rst_n, skid_valid_reg |-> main_valid_reg, "skid holds data ahead of main")
    `ASSERT_NEVER(a_no_overflow, clk, rst_n, res_valid && skid_valid_reg, "result pushed into full buffer")
    `ASSERT_PROP(a_skid_moves_up, clk, rst_n, (skid_valid_reg && out_ready) |=> (main_valid_reg && main_reg == $past(skid_reg)), "skid entry not advanced")

endmodule

@@ src/oversampled_pad_report_decoder.sv @@
// Top level of the oversampled pad report decoder.
// Depends on opd_pkg, opd_cfg_regs, opd_frame_tracker and opd_out_buffer.
//
//  channel  | dir | handshake         | payload
//  s_       | in  | s_tvalid/s_tready | tdata: sample_byte; tuser: frame_start
//  m_       | out | m_tvalid/m_tready | tdata: report_value, report_position; tlast
//  cfg_     | in  | cfg_we            | cfg_index, cfg_data
//
// One sample byte per cycle while s_tready is high; every fourth byte of
// an accepted frame yields a report byte on m_ in the next cycle when the buffer is empty.
// s_tready depends only on the skid register, so inputs flow while a result waits.
// Reset clears frame position, partial bits, rejection flag and buffer valids.
// A stalled sink holds two results before s_tready drops.
module oversampled_pad_report_decoder
    import opd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] sample_byte
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] report_value, [10:8] report_position, rest 0
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t    cfg;
    logic    in_fire;
    logic    res_valid;
    result_t res;
    result_t out_res;
    logic    space;

    opd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign s_tready = space;
    assign in_fire  = s_tvalid && space;

    opd_frame_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_fire     (in_fire),
        .sample_byte (s_tdata),
        .frame_start (s_tuser),
        .res_valid   (res_valid),
        .res         (res)
    );

    opd_out_buffer u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {5'd0, out_res.position, out_res.value};
    assign m_tlast = out_res.last;

endmodule

@@ bench/tb_oversampled_pad_report_decoder.sv @@
// Testbench for oversampled_pad_report_decoder: streams sample bytes, decodes
// them in a cycle-free tracker and checks every report byte in order.
// Depends on opd_pkg and the decoder RTL.
module tb_oversampled_pad_report_decoder;
    import opd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 285;
    localparam int MAX_REPORTED  = 10;

    class report_tracker;
        logic [1:0] vote_threshold;
        logic [7:0] header_pattern;
        logic [7:0] centre_offset;
        int         sample_index;
        logic [5:0] partial_bits;
        bit         frame_rejected;
        result_t    pending_reports[$];
        int         mismatches;

        function new();
            vote_threshold = VOTE_THRESHOLD_RESET;
            header_pattern = HEADER_PATTERN_RESET;
            centre_offset  = CENTRE_OFFSET_RESET;
            sample_index   = 0;
            partial_bits   = '0;
            frame_rejected = 1'b0;
            mismatches     = 0;
        endfunction

        function void write_register(reg_index_t index, logic [7:0] data);
            case (index)
                REG_VOTE_THRESHOLD: vote_threshold = data[1:0];
                REG_HEADER_PATTERN: header_pattern = data;
                REG_CENTRE_OFFSET:  centre_offset  = data;
                default: ;
            endcase
        endfunction

        function logic cell_high(logic [3:0] samples);
            return $countones(samples) > int'(vote_threshold);
        endfunction

        function void note_sample(logic [7:0] sample_byte, logic frame_start);
            logic [1:0] cells;
            logic [7:0] report;
            int         byte_index;
            result_t    expected;
            if (frame_start || sample_index >= 4 * REPORT_BYTES)
                sample_index = 0;
            if (sample_index == 0)
            begin
                frame_rejected = (sample_byte != header_pattern);
                partial_bits   = '0;
            end
            cells = {cell_high(sample_byte[7:4]), cell_high(sample_byte[3:0])};
            if (sample_index % 4 == 0)
                partial_bits = '0;
            if (sample_index % 4 == 3)
            begin
                report     = {partial_bits, cells};
                byte_index = sample_index / 4;
                if (byte_index == 2 || byte_index == 4)
                    report = report + centre_offset;
                else if (byte_index == 3 || byte_index == 5)
                    report = centre_offset - report;
                if (!frame_rejected)
                begin
                    expected.value    = report;
                    expected.position = byte_index[2:0];
                    expected.last     = (byte_index == REPORT_BYTES - 1);
                    pending_reports.push_back(expected);
                end
                partial_bits = '0;
            end
            else
                partial_bits = {partial_bits[3:0], cells};
            sample_index++;
        endfunction

        function void check_report(logic [7:0] value, logic [2:0] position, logic last);
            result_t expected;
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("unexpected report: value %0d position %0d last %0b",
                             value, position, last);
                return;
            end
            expected = pending_reports.pop_front();
            if (value !== expected.value || position !== expected.position ||
                last !== expected.last)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("report mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                             expected.value, expected.position, expected.last,
                             value, position, last);
            end
        endfunction

        function int outstanding();
            return pending_reports.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    report_tracker tracker = new();
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left   = 0;
    int cycle_count = 0;
    int items_sent  = 0;

    oversampled_pad_report_decoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_report(m_tdata[7:0], m_tdata[10:8], m_tlast);
    end

    task automatic send_sample(input logic [7:0] sample_byte, input logic frame_start);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample_byte;
        s_tuser  <= frame_start;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_sample(sample_byte, frame_start);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_register(input reg_index_t index, input logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker.write_register(index, data);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct, input int hold);
        s_tvalid <= 1'b0;
        @(posedge clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        hold_left   = hold;
        @(negedge clk);
    endtask

    function automatic logic [7:0] random_sample();
        case ($urandom_range(3))
            0:       return {4'($urandom_range(15)), 4'($urandom_range(15))};
            1:       return $urandom_range(1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_frame();
        int kind;
        int count;
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            send_sample(tracker.header_pattern, 1'b1);
            repeat (4 * REPORT_BYTES - 1) send_sample(random_sample(), 1'b0);
        end
        else if (kind < 80)
        begin
            send_sample(8'($urandom_range(255)), 1'b1);
            repeat (4 * REPORT_BYTES - 1) send_sample(random_sample(), 1'b0);
        end
        else if (kind < 88)
        begin
            count = $urandom_range(4 * REPORT_BYTES - 2, 1);
            send_sample(tracker.header_pattern, 1'b1);
            repeat (count) send_sample(random_sample(), 1'b0);
        end
        else if (kind < 95)
        begin
            send_sample(tracker.header_pattern, 1'b0);
            repeat (4 * REPORT_BYTES - 1) send_sample(random_sample(), 1'b0);
        end
        else
        begin
            count = $urandom_range(10, 1);
            repeat (count) send_sample(random_sample(), 1'($urandom_range(1)));
        end
    endtask

    logic [8:0] directed_items [24];
    logic [1:0] phase_threshold [PHASES];
    logic [7:0] phase_header    [PHASES];
    logic [7:0] phase_offset    [PHASES];

    initial
    begin
        int phase;
        int phase_end;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_VOTE_THRESHOLD;
        cfg_data  = '0;
        rst_n     = 1'b0;

        // {frame_start, sample_byte}: first five report bytes of an accepted frame,
        // then a frame whose header does not match
        directed_items = '{
            9'h111, 9'h0FF, 9'h0FF, 9'h0FF,
            9'h000, 9'h000, 9'h000, 9'h000,
            9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
            9'h0F0, 9'h0F0, 9'h00F, 9'h0E7,
            9'h07E, 9'h077, 9'h0EE, 9'h0FF,
            9'h100, 9'h0FF, 9'h0FF, 9'h0FF
        };
        phase_threshold = '{2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd0};
        phase_header    = '{8'h11, 8'h00, 8'hFF, 8'hA5, 8'h3C, 8'h11};
        phase_offset    = '{8'd127, 8'h00, 8'hFF, 8'h80, 8'h01, 8'hFE};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_idling(24, 81, 0);
        foreach (directed_items[i])
            send_sample(directed_items[i][7:0], directed_items[i][8]);

        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain();
                write_register(REG_VOTE_THRESHOLD, {6'b0, phase_threshold[phase]});
                write_register(REG_HEADER_PATTERN, phase_header[phase]);
                write_register(REG_CENTRE_OFFSET, phase_offset[phase]);
            end
            if (phase < 2)
                set_idling(24, 81, (phase == 1) ? 400 : 0);
            else if (phase < 4)
                set_idling(81, 24, 0);
            else
                set_idling(0, 0, 0);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                send_frame();
        end
        drain();

        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
